// File: rtl/core/b32dv_pkg.sv
package b32dv_pkg;

	localparam logic [7:0]  PAD_CHAR  = 8'h3D;
	localparam logic [15:0] CAP_RESET = 16'hFFFF;
	localparam int unsigned GROUP_BYTES = 5;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CHAR = 2'd1;
	localparam logic [1:0] ERR_PAD  = 2'd2;
	localparam logic [1:0] ERR_LEN  = 2'd3;

	typedef struct packed {
		logic        invalid;
		logic [4:0]  value;
	} sym_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic        done_res;
		logic [1:0]  error_code;
		logic        truncated;
		logic [15:0] byte_count;
		logic [15:0] group_offset;
	} res_word_t;

	function automatic sym_t sym_decode(input logic [7:0] c);
		sym_t s;
		s.invalid = 1'b0;
		s.value   = 5'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			s.value = 5'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			s.value = 5'(c - 8'h61);
		end else if (c inside {[8'h32:8'h37]}) begin
			s.value = 5'(c - 8'h32 + 8'd26);
		end else if (c == 8'h30) begin
			s.value = 5'd14;
		end else if (c == 8'h31) begin
			s.value = 5'd11;
		end else if (c == 8'h38) begin
			s.value = 5'd1;
		end else begin
			s.invalid = 1'b1;
		end
		return s;
	endfunction

endpackage

// File: rtl/core/b32dv_char_if.sv
interface b32dv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

// File: rtl/core/b32dv_res_if.sv
interface b32dv_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        done_res;
	logic [1:0]  error_code;
	logic        truncated;
	logic [15:0] byte_count;
	logic [15:0] group_offset;

	modport source (output valid, output data_byte, output byte_valid, output done_res,
		output error_code, output truncated, output byte_count, output group_offset,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input done_res,
		input error_code, input truncated, input byte_count, input group_offset,
		output ready);
endinterface

// File: rtl/core/b32dv_cfg_if.sv
interface b32dv_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_capacity;

	modport source (output valid, output out_capacity, input ready);
	modport sink (input valid, input out_capacity, output ready);
endinterface

// File: rtl/core/base32_decoder_validator_unit.sv
// channel  | dir | payload                                           | word moves when
// chars    | in  | ch[7:0], last                                     | valid & ready
// results  | out | data_byte, byte_valid, done_res, error_code,      | valid & ready
//          |     | truncated, byte_count, group_offset               |
// cfg      | in  | out_capacity[15:0]                                | valid & ready (always ready)
//
// One character per cycle while the queue has room: an input register feeds
// a single decode step that writes up to two words (decoded byte, then status
// on last) into a 4-word result queue, whose head is the output port. The
// output port moves one word per cycle while results.ready is high, so strings
// with many words per character drain at that rate. Reset clears all stream
// state and sets out_capacity to 65535. The input register holds while the
// queue has fewer than two free slots.
module base32_decoder_validator_unit #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	b32dv_char_if.sink  chars,
	b32dv_res_if.source results,
	b32dv_cfg_if.sink   cfg
);

	localparam int unsigned CW    = COUNT_WIDTH;
	localparam int unsigned EW    = ((CW > 16) ? CW : 16) + 1;
	localparam int unsigned XW    = CW + 16;
	localparam int unsigned DEPTH = 4;
	localparam int unsigned PW    = $clog2(DEPTH);
	localparam int unsigned NW    = PW + 1;

	logic [15:0]   cap_q;

	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          last_s1;

	logic [11:0]   acc_q;
	logic [3:0]    bc_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] dc_q;
	logic [CW-1:0] lgs_q;
	logic          pad_q;
	logic [1:0]    err_q;
	logic          full_q;

	b32dv_pkg::res_word_t fifo_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;

	logic          advance;
	logic          pop;
	logic [2:0]    pos;
	b32dv_pkg::sym_t sym;
	logic          room;

	logic [11:0]   acc_n;
	logic [3:0]    bc_n;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] dc_n;
	logic [CW-1:0] lgs_n;
	logic          pad_n;
	logic [1:0]    err_n;
	logic          full_n;
	logic          emit;
	logic [7:0]    byte_d;
	logic [11:0]   acc_t;
	logic [3:0]    bc_t;
	logic [11:0]   acc_w;
	logic [3:0]    bc_w;
	logic [2:0]    sh;
	logic [XW-1:0] dc_x;
	logic [XW-1:0] lgs_x;

	b32dv_pkg::res_word_t byte_word;
	b32dv_pkg::res_word_t stat_word;
	logic [NW-1:0] n_wr;
	logic [PW-1:0] stat_ptr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= b32dv_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.out_capacity;
		end
	end

	assign advance     = valid_s1 && (cnt_q <= NW'(DEPTH - 2));
	assign chars.ready = !valid_s1 || advance;
	assign pop         = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	assign pos     = idx_q[2:0];
	assign sym     = b32dv_pkg::sym_decode(ch_s1);
	assign idx_inc = idx_q + 1'b1;
	assign room    = (EW'(dc_q) + EW'(b32dv_pkg::GROUP_BYTES)) <= EW'(cap_q);

	always_comb begin
		acc_n  = acc_q;
		bc_n   = bc_q;
		dc_n   = dc_q;
		lgs_n  = lgs_q;
		pad_n  = pad_q;
		err_n  = err_q;
		full_n = full_q;
		emit   = 1'b0;
		byte_d = '0;
		acc_t  = '0;
		bc_t   = '0;
		acc_w  = '0;
		bc_w   = '0;
		sh     = '0;
		if (err_q == b32dv_pkg::ERR_NONE) begin
			if (pad_q) begin
				if (ch_s1 != b32dv_pkg::PAD_CHAR || pos == 3'd0) begin
					err_n = b32dv_pkg::ERR_PAD;
				end
			end else if (ch_s1 == b32dv_pkg::PAD_CHAR) begin
				if (!(pos inside {3'd2, 3'd4, 3'd5, 3'd7})) begin
					err_n = b32dv_pkg::ERR_PAD;
				end
				pad_n = 1'b1;
				acc_n = '0;
				bc_n  = '0;
			end else if (sym.invalid) begin
				err_n = b32dv_pkg::ERR_CHAR;
			end else if (!full_q) begin
				if (pos == 3'd0 && !room) begin
					full_n = 1'b1;
				end else begin
					acc_t = (pos == 3'd0) ? 12'd0 : acc_q;
					bc_t  = (pos == 3'd0) ? 4'd0 : bc_q;
					if (pos == 3'd0) begin
						lgs_n = idx_q;
					end
					acc_w = {acc_t[6:0], sym.value};
					bc_w  = bc_t + 4'd5;
					if (bc_w >= 4'd8) begin
						emit   = 1'b1;
						sh     = 3'(bc_w - 4'd8);
						byte_d = 8'(acc_w >> sh);
						bc_n   = bc_w - 4'd8;
						acc_n  = acc_w & ((12'd1 << bc_n) - 12'd1);
						dc_n   = dc_q + 1'b1;
					end else begin
						acc_n = acc_w;
						bc_n  = bc_w;
					end
				end
			end
		end
	end

	assign dc_x  = XW'(dc_n);
	assign lgs_x = XW'(lgs_n);

	always_comb begin
		byte_word            = '0;
		byte_word.data_byte  = byte_d;
		byte_word.byte_valid = 1'b1;
		stat_word              = '0;
		stat_word.done_res     = 1'b1;
		stat_word.error_code   = (idx_inc[2:0] != 3'd0) ? b32dv_pkg::ERR_LEN : err_n;
		stat_word.truncated    = full_n;
		stat_word.byte_count   = dc_x[15:0];
		stat_word.group_offset = lgs_x[15:0];
	end

	assign n_wr     = advance ? (NW'(emit) + NW'(last_s1)) : '0;
	assign stat_ptr = wr_ptr_q + PW'(emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bc_q   <= '0;
			idx_q  <= '0;
			dc_q   <= '0;
			lgs_q  <= '0;
			pad_q  <= 1'b0;
			err_q  <= b32dv_pkg::ERR_NONE;
			full_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				acc_q  <= '0;
				bc_q   <= '0;
				idx_q  <= '0;
				dc_q   <= '0;
				lgs_q  <= '0;
				pad_q  <= 1'b0;
				err_q  <= b32dv_pkg::ERR_NONE;
				full_q <= 1'b0;
			end else begin
				acc_q  <= acc_n;
				bc_q   <= bc_n;
				idx_q  <= idx_inc;
				dc_q   <= dc_n;
				lgs_q  <= lgs_n;
				pad_q  <= pad_n;
				err_q  <= err_n;
				full_q <= full_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			fifo_q[wr_ptr_q] <= byte_word;
		end
		if (advance && last_s1) begin
			fifo_q[stat_ptr] <= stat_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_wr);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			cnt_q    <= cnt_q + n_wr - NW'(pop);
		end
	end

	assign results.valid        = (cnt_q != '0);
	assign results.data_byte    = fifo_q[rd_ptr_q].data_byte;
	assign results.byte_valid   = fifo_q[rd_ptr_q].byte_valid;
	assign results.done_res     = fifo_q[rd_ptr_q].done_res;
	assign results.error_code   = fifo_q[rd_ptr_q].error_code;
	assign results.truncated    = fifo_q[rd_ptr_q].truncated;
	assign results.byte_count   = fifo_q[rd_ptr_q].byte_count;
	assign results.group_offset = fifo_q[rd_ptr_q].group_offset;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= NW'(DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n) bc_q < 4'd8)
		else $error("bit count holds a whole byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |-> err_q == b32dv_pkg::ERR_NONE && !pad_q && !full_q)
		else $error("byte emitted after decoding ended");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> idx_q == '0 && dc_q == '0 && err_q == b32dv_pkg::ERR_NONE
			&& !pad_q && !full_q)
		else $error("stream state not cleared after last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 |=> idx_q == $past(idx_inc))
		else $error("character index did not advance");

endmodule
